// ===== hdl/esd_pkg.sv =====
package esd_pkg;

    localparam int unsigned DEPTH_DEFAULT       = 16;
    localparam int unsigned ENTRY_BYTES_DEFAULT = 8;

    localparam int unsigned WORD_W    = 64;
    localparam int unsigned REQ_W     = 3;
    localparam int unsigned CAP_W     = 5;
    localparam int unsigned CAP_RESET = 16;
    localparam int unsigned CAP_MIN   = 2;
    // byte left out of the search compare
    localparam int unsigned SKIP_BYTE = 2;

    typedef enum logic [REQ_W-1:0] {
        REQ_PUSH   = 3'd0,
        REQ_POP    = 3'd1,
        REQ_DELETE = 3'd2,
        REQ_SEARCH = 3'd3,
        REQ_CLEAR  = 3'd4
    } t_req;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_APPLY = 2'b10
    } t_state;

    // control broadcast to every cell
    typedef struct packed {
        logic capture;     // latch compare result against the key bus
        logic search_mask; // ignore the skipped byte in the compare
        logic push;        // cell at top+1 loads the key
        logic del;         // cells from the first hit below top load their neighbor
    } t_cell_ctrl;

endpackage

// ===== hdl/entry_stack_with_search_delete_top.sv =====
// Stack of entries with push, pop, delete-by-key, search and clear. One
// request is taken on start while busy is low; busy then stays high for one
// cycle; as busy falls the result is registered onto the o_ ports and held
// until the next request, with o_done high for exactly one cycle. The accept
// cycle latches the per-slot compare in every cell; the busy cycle resolves
// the first hit along the cell row, shifts on delete and updates the top. The
// receiver cannot stall; results must be taken in the cycle they are shown.
// The capacity register may be written at any time the block is idle.
module entry_stack_with_search_delete_top #(
    parameter int unsigned DEPTH       = esd_pkg::DEPTH_DEFAULT,
    parameter int unsigned ENTRY_BYTES = esd_pkg::ENTRY_BYTES_DEFAULT
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [esd_pkg::REQ_W-1:0]  i_req_type,
    input  logic [esd_pkg::WORD_W-1:0] i_entry_in,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [esd_pkg::CAP_W-1:0]  i_cfg_data,
    output logic                       o_done,
    output logic                       o_ok,
    output logic [esd_pkg::WORD_W-1:0] o_entry_out,
    output logic [$clog2(DEPTH)-1:0]   o_match_index,
    output logic                       o_found,
    output logic [$clog2(DEPTH)-1:0]   o_top_level,
    output logic                       o_full_flag
);
    import esd_pkg::*;

    localparam int unsigned IW = $clog2(DEPTH);
    localparam int unsigned EW = 8 * ENTRY_BYTES;
    localparam int unsigned CW = ((IW + 1) > CAP_W) ? (IW + 1) : CAP_W;

    t_state           r_state;
    t_req             r_req;
    logic [EW-1:0]    r_key;
    logic [IW-1:0]    r_top, n_top;
    logic [CAP_W-1:0] r_cap;

    logic             r_done;
    logic             r_ok, n_ok;
    logic [EW-1:0]    r_eout, n_eout;
    logic [IW-1:0]    r_midx, n_midx;
    logic             r_found, n_found;
    logic             r_full, n_full;

    logic             accept;
    logic [EW-1:0]    key_bus;
    t_cell_ctrl       cell_ctrl;
    logic [CW-1:0]    eff_cap;
    logic             full_now;

    logic [EW-1:0]    cell_data [DEPTH];
    logic             hit_chain [DEPTH];
    logic             first_hit [DEPTH];
    logic [EW-1:0]    top_data;
    logic [IW-1:0]    first_idx;
    logic             any_hit;

    assign accept      = start && (r_state == ST_IDLE);
    assign busy        = (r_state == ST_APPLY);
    assign o_cfg_ready = 1'b1;

    // key bus: raw input while capturing, the latched key while applying
    assign key_bus = (r_state == ST_IDLE) ? i_entry_in[EW-1:0] : r_key;

    always_comb begin
        cell_ctrl             = '0;
        cell_ctrl.capture     = accept;
        cell_ctrl.search_mask = (t_req'(i_req_type) == REQ_SEARCH);
        cell_ctrl.push        = busy && (r_req == REQ_PUSH) && !full_now;
        cell_ctrl.del         = busy && (r_req == REQ_DELETE);
    end

    // capacity clamped to 2..DEPTH
    always_comb begin
        if (CW'(r_cap) < CW'(CAP_MIN)) begin
            eff_cap = CW'(CAP_MIN);
        end else if (CW'(r_cap) > CW'(DEPTH)) begin
            eff_cap = CW'(DEPTH);
        end else begin
            eff_cap = CW'(r_cap);
        end
    end

    assign full_now = (CW'(r_top) >= (eff_cap - CW'(1)));

    // slot 0 is never used
    assign cell_data[0] = '0;
    assign hit_chain[0] = 1'b0;
    assign first_hit[0] = 1'b0;

    for (genvar g = 1; g < DEPTH; g++) begin : g_cell
        logic [EW-1:0] next_data;
        if (g == DEPTH - 1) begin : g_last
            assign next_data = cell_data[g];
        end else begin : g_mid
            assign next_data = cell_data[g+1];
        end
        esd_cell #(
            .IDX (g),
            .IW  (IW),
            .EW  (EW)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctrl      (cell_ctrl),
            .i_key       (key_bus),
            .i_top       (r_top),
            .i_next_data (next_data),
            .i_hit_prior (hit_chain[g-1]),
            .o_data      (cell_data[g]),
            .o_hit_chain (hit_chain[g]),
            .o_first     (first_hit[g])
        );
    end

    assign any_hit = hit_chain[DEPTH-1];

    always_comb begin
        top_data  = '0;
        first_idx = '0;
        for (int i = 1; i < DEPTH; i++) begin
            if (r_top == IW'(i)) begin
                top_data = top_data | cell_data[i];
            end
            if (first_hit[i]) begin
                first_idx = first_idx | IW'(i);
            end
        end
    end

    always_comb begin
        n_top   = r_top;
        n_ok    = 1'b0;
        n_eout  = '0;
        n_midx  = '0;
        n_found = 1'b0;
        unique case (r_req)
            REQ_PUSH: begin
                if (!full_now) begin
                    n_top = r_top + IW'(1);
                    n_ok  = 1'b1;
                end
            end
            REQ_POP: begin
                if (r_top != '0) begin
                    n_eout = top_data;
                    n_top  = r_top - IW'(1);
                    n_ok   = 1'b1;
                end
            end
            REQ_DELETE: begin
                if (any_hit) begin
                    n_top = r_top - IW'(1);
                    n_ok  = 1'b1;
                end
            end
            REQ_SEARCH: begin
                n_found = any_hit;
                n_ok    = any_hit;
                n_midx  = any_hit ? first_idx : r_top;
            end
            REQ_CLEAR: begin
                n_top = '0;
                n_ok  = 1'b1;
            end
            default: begin
            end
        endcase
        n_full = (CW'(n_top) >= (eff_cap - CW'(1)));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_top   <= '0;
            r_cap   <= CAP_W'(CAP_RESET);
            r_done  <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_cap <= i_cfg_data;
            end
            r_done <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_state <= ST_APPLY;
                    end
                end
                ST_APPLY: begin
                    r_top   <= n_top;
                    r_done  <= 1'b1;
                    r_state <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req <= t_req'(i_req_type);
            r_key <= i_entry_in[EW-1:0];
        end
        if (busy) begin
            r_ok    <= n_ok;
            r_eout  <= n_eout;
            r_midx  <= n_midx;
            r_found <= n_found;
            r_full  <= n_full;
        end
    end

    assign o_done        = r_done;
    assign o_ok          = r_ok;
    assign o_entry_out   = WORD_W'(r_eout);
    assign o_match_index = r_midx;
    assign o_found       = r_found;
    assign o_top_level   = r_top;
    assign o_full_flag   = r_full;

endmodule

// ===== hdl/esd_cell.sv =====
module esd_cell #(
    parameter int unsigned IDX   = 1,
    parameter int unsigned IW    = 4,
    parameter int unsigned EW    = 64
) (
    input  logic                  i_clk,
    input  esd_pkg::t_cell_ctrl   i_ctrl,
    input  logic [EW-1:0]         i_key,
    input  logic [IW-1:0]         i_top,
    input  logic [EW-1:0]         i_next_data,
    input  logic                  i_hit_prior,
    output logic [EW-1:0]         o_data,
    output logic                  o_hit_chain,
    output logic                  o_first
);
    import esd_pkg::*;

    logic [EW-1:0] r_data;
    logic          r_hit;
    logic [EW-1:0] cmp_mask;
    logic          occupied;
    logic          below_top;
    logic          at_push_slot;

    always_comb begin
        cmp_mask = '1;
        if (i_ctrl.search_mask) begin
            cmp_mask[SKIP_BYTE*8 +: 8] = 8'h00;
        end
    end

    assign occupied     = (IW'(IDX) <= i_top);
    assign below_top    = (IW'(IDX) < i_top);
    assign at_push_slot = (({1'b0, i_top} + (IW+1)'(1)) == (IW+1)'(IDX));

    always_ff @(posedge i_clk) begin
        if (i_ctrl.capture) begin
            r_hit <= occupied && (((r_data ^ i_key) & cmp_mask) == '0);
        end
    end

    // stored word: push writes the key, delete pulls the neighbor down
    always_ff @(posedge i_clk) begin
        if (i_ctrl.push && at_push_slot) begin
            r_data <= i_key;
        end else if (i_ctrl.del && o_hit_chain && below_top) begin
            r_data <= i_next_data;
        end
    end

    assign o_data      = r_data;
    assign o_hit_chain = r_hit | i_hit_prior;
    assign o_first     = r_hit & ~i_hit_prior;

endmodule
